// ===== rtl/core/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// shared constants and types of the binary morphology filter
// ----------------------------------------------------------------------------
package bmf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_KERNEL = 7;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 13;
   localparam int DLY_W      = 14;
   localparam int WORD_W     = 2 * (MAX_KERNEL - 1);

   typedef enum logic [1:0] {
      MODE_DILATE = 2'd0,
      MODE_ERODE  = 2'd1,
      MODE_OPEN   = 2'd2,
      MODE_CLOSE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE   = 2'd0,
      CSR_KERNEL = 2'd1,
      CSR_WIDTH  = 2'd2,
      CSR_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } pos_type;

   // bit 0 white, bit 1 black
   typedef struct packed {
      logic [1:0] bits;
      pos_type    src;
      pos_type    ctr;
      logic       ctr_vld;
      pos_type    aux;
      logic       aux_vld;
   } item_type;

   typedef struct packed {
      logic    vld;
      logic    level;
      pos_type ctr;
      logic    ctr_vld;
      pos_type aux;
      logic    aux_vld;
   } res_type;

   typedef struct packed {
      logic [2:0]  ksize;
      logic [1:0]  after;
      logic [10:0] width;
      logic [11:0] height;
      logic        erode;
   } stage_cfg_type;

endpackage

// ===== rtl/core/bmf_ram.sv =====
// ----------------------------------------------------------------------------
// bmf_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bmf_stage.sv =====
// ----------------------------------------------------------------------------
// bmf_stage
// one morphology pass: column line store, window columns and or-reduce
// ----------------------------------------------------------------------------
module bmf_stage
   import bmf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  item_type      in_item,
   input  stage_cfg_type cfg,
   output res_type       res
);

   typedef logic [MAX_KERNEL-1:0][1:0] colv_type;

   item_type          item_ff;
   logic              item_vld_ff;
   logic              fwd_ff;
   logic [WORD_W-1:0] fwd_data_ff;
   colv_type          colbuf_ff [MAX_KERNEL-1];
   res_type           res_ff;

   logic              rd_en;
   logic              wr_en;
   logic [WORD_W-1:0] ram_q;
   logic [WORD_W-1:0] old_word;
   logic [WORD_W-1:0] new_word;
   colv_type          col_vec;
   logic [MAX_KERNEL-1:0] row_ok;
   logic [MAX_KERNEL-1:0] col_ok;
   logic              hit;
   logic signed [14:0] rr;
   logic signed [14:0] cc;
   colv_type          cur;

   assign rd_en = adv && in_valid;
   assign wr_en = adv && item_vld_ff;

   bmf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_ff.src.col),
      .wr_data (new_word),
      .rd_en   (rd_en),
      .rd_addr (in_item.src.col),
      .rd_data (ram_q)
   );

   // write of the same column in the same cycle wins over the ram
   assign old_word = fwd_ff ? fwd_data_ff : ram_q;

   always_comb begin
      col_vec[0] = item_ff.bits;
      for (int m = 1; m < MAX_KERNEL; m++) begin
         col_vec[m] = old_word[2*(m-1) +: 2];
      end
      for (int m = 1; m < MAX_KERNEL; m++) begin
         new_word[2*(m-1) +: 2] = col_vec[m-1];
      end
   end

   always_comb begin
      for (int m = 0; m < MAX_KERNEL; m++) begin
         rr = $signed({2'b00, item_ff.ctr.row}) + $signed({13'b0, cfg.after}) - 15'(m);
         row_ok[m] = (rr >= 15'sd0) && (rr < $signed({3'b000, cfg.height}));
      end
      for (int d = 0; d < MAX_KERNEL; d++) begin
         cc = $signed({5'b00000, item_ff.ctr.col}) + $signed({13'b0, cfg.after}) - 15'(d);
         col_ok[d] = (cc >= 15'sd0) && (cc < $signed({4'b0000, cfg.width}));
      end
      hit = 1'b0;
      for (int d = 0; d < MAX_KERNEL; d++) begin
         cur = (d == 0) ? col_vec : colbuf_ff[(d == 0) ? 0 : d-1];
         for (int m = 0; m < MAX_KERNEL; m++) begin
            if ((3'(d) < cfg.ksize) && (3'(m) < cfg.ksize)) begin
               if (row_ok[m] && col_ok[d]) begin
                  hit = hit | (cfg.erode ? cur[m][1] : cur[m][0]);
               end else begin
                  hit = hit | cfg.erode;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         res_ff.vld  <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (adv) begin
         item_vld_ff <= in_valid;
         res_ff.vld  <= item_vld_ff;
         if (rd_en) begin
            fwd_ff <= wr_en && (in_item.src.col == item_ff.src.col);
         end
      end
      if (adv) begin
         if (in_valid) begin
            item_ff     <= in_item;
            fwd_data_ff <= new_word;
         end
         if (item_vld_ff) begin
            colbuf_ff[0] <= col_vec;
            for (int j = 1; j < MAX_KERNEL-1; j++) begin
               colbuf_ff[j] <= colbuf_ff[j-1];
            end
            res_ff.level   <= cfg.erode ? ~hit : hit;
            res_ff.ctr     <= item_ff.ctr;
            res_ff.ctr_vld <= item_ff.ctr_vld;
            res_ff.aux     <= item_ff.aux;
            res_ff.aux_vld <= item_ff.aux_vld;
         end
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/core/binary_morphology_filter.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_filter
// dilation, erosion, opening and closing of a raster bgr stream
// ----------------------------------------------------------------------------
// throughput: one request per cycle, stalls only while the result register is full
// pipeline: a result passes the item and result registers of each pass (one pass for
//   dilation and erosion, two for opening and closing) and then the response register;
//   the window itself lags the stream by a*(w+1) positions per pass, a = (k-1)/2
// reset: synchronous, clears counters and pipeline, loads default registers;
//   line stores need no clearing pass, rows outside the frame are masked
module binary_morphology_filter
   import bmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_blue, in_green, in_red
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_level
   output logic        rsp_tuser,   // out_last_in_row
   output logic        rsp_tlast,   // out_last_of_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   // configuration registers
   logic [1:0]  mode_ff;
   logic [2:0]  ksize_ff;
   logic [10:0] width_ff;
   logic [11:0] height_ff;

   // stream position and the two window centers behind it
   pos_type          p0_ff;
   pos_type          p1_ff;
   pos_type          p2_ff;
   logic [DLY_W-1:0] lag1_ff;
   logic [DLY_W-1:0] lag2_ff;

   logic        rsp_vld_ff;
   logic [7:0]  rsp_level_ff;
   logic        rsp_row_ff;
   logic        rsp_frame_ff;

   logic          adv;
   logic          accept;
   logic          step;
   logic          cascade;
   logic [2:0]    k_eff;
   logic [1:0]    after;
   logic [10:0]   w_eff;
   logic [11:0]   h_eff;
   logic [DLY_W-1:0] d1;
   logic          v1;
   logic          v2;
   logic          pix_phase;
   logic          frame_end;
   logic          white;
   logic          black;
   logic [7:0]    blue;
   logic [7:0]    green;
   logic [7:0]    red;
   item_type      s1_item;
   item_type      s2_item;
   stage_cfg_type s1_cfg;
   stage_cfg_type s2_cfg;
   res_type       s1_res;
   res_type       s2_res;
   res_type       fin;
   logic          emit;
   logic          fin_last_row;
   pos_type       p0_in;
   pos_type       p1_in;
   pos_type       p2_in;

   // effective geometry with out of range values clamped
   assign k_eff   = (ksize_ff == 3'd0) ? 3'd1 : ksize_ff;
   assign after   = 2'((k_eff - 3'd1) >> 1);
   assign w_eff   = (width_ff == 11'd0) ? 11'd1 :
                    (width_ff > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_ff;
   assign h_eff   = (height_ff == 12'd0) ? 12'd1 : height_ff;
   assign d1      = DLY_W'(after) * (DLY_W'(w_eff) + DLY_W'(1));
   assign cascade = (mode_ff == MODE_OPEN) || (mode_ff == MODE_CLOSE);

   // whole pipeline moves while the result register can take a new value
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;
   assign csr_ready  = 1'b1;

   assign pix_phase = p0_ff.row < ROW_W'(h_eff);
   // flush ticks during the pixel phase are dropped without advancing
   assign step      = accept && (!req_tuser || !pix_phase);
   assign v1        = lag1_ff == d1;
   assign v2        = lag2_ff == d1;

   assign frame_end = cascade ?
      (v1 && v2 && p2_ff.row == ROW_W'(h_eff - 12'd1) &&
       11'(p2_ff.col) == w_eff - 11'd1) :
      (v1 && p1_ff.row == ROW_W'(h_eff - 12'd1) && 11'(p1_ff.col) == w_eff - 11'd1);

   // pixel classification
   assign blue  = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign red   = req_tdata[23:16];
   assign white = (blue == 8'hFF) || (green == 8'hFF) || (red == 8'hFF);
   assign black = (blue == 8'h00) || (green == 8'h00) || (red == 8'h00);

   // next raster positions
   always_comb begin
      p0_in = p0_ff;
      if (11'(p0_ff.col) == w_eff - 11'd1) begin
         p0_in.col = '0;
         p0_in.row = p0_ff.row + ROW_W'(1);
      end else begin
         p0_in.col = p0_ff.col + COL_W'(1);
      end
      p1_in = p1_ff;
      if (11'(p1_ff.col) == w_eff - 11'd1) begin
         p1_in.col = '0;
         p1_in.row = p1_ff.row + ROW_W'(1);
      end else begin
         p1_in.col = p1_ff.col + COL_W'(1);
      end
      p2_in = p2_ff;
      if (11'(p2_ff.col) == w_eff - 11'd1) begin
         p2_in.col = '0;
         p2_in.row = p2_ff.row + ROW_W'(1);
      end else begin
         p2_in.col = p2_ff.col + COL_W'(1);
      end
   end

   // first pass sees the input stream
   always_comb begin
      s1_item.bits    = pix_phase ? {black, white} : 2'b10;
      s1_item.src     = p0_ff;
      s1_item.ctr     = p1_ff;
      s1_item.ctr_vld = v1;
      s1_item.aux     = p2_ff;
      s1_item.aux_vld = v1 && v2;
   end

   // second pass sees first pass results at their centers
   always_comb begin
      s2_item.bits    = {~s1_res.level, s1_res.level};
      s2_item.src     = s1_res.ctr;
      s2_item.ctr     = s1_res.aux;
      s2_item.ctr_vld = s1_res.aux_vld;
      s2_item.aux     = s1_res.aux;
      s2_item.aux_vld = 1'b0;
   end

   always_comb begin
      s1_cfg.ksize  = k_eff;
      s1_cfg.after  = after;
      s1_cfg.width  = w_eff;
      s1_cfg.height = h_eff;
      s1_cfg.erode  = (mode_ff == MODE_ERODE) || (mode_ff == MODE_OPEN);
      s2_cfg        = s1_cfg;
      s2_cfg.erode  = mode_ff == MODE_CLOSE;
   end

   bmf_stage u_stage1 (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (step),
      .in_item  (s1_item),
      .cfg      (s1_cfg),
      .res      (s1_res)
   );

   bmf_stage u_stage2 (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s1_res.vld && s1_res.ctr_vld),
      .in_item  (s2_item),
      .cfg      (s2_cfg),
      .res      (s2_res)
   );

   // final pass result, centers in drain rows give nothing
   assign fin  = cascade ? s2_res : s1_res;
   assign emit = fin.vld && fin.ctr_vld && (fin.ctr.row < ROW_W'(h_eff));
   assign fin_last_row = 11'(fin.ctr.col) == w_eff - 11'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_DILATE;
         ksize_ff   <= 3'd3;
         width_ff   <= 11'd640;
         height_ff  <= 12'd480;
         p0_ff      <= '0;
         p1_ff      <= '0;
         p2_ff      <= '0;
         lag1_ff    <= '0;
         lag2_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MODE:   mode_ff   <= csr_data[1:0];
               CSR_KERNEL: ksize_ff  <= csr_data[2:0];
               CSR_WIDTH:  width_ff  <= csr_data[10:0];
               CSR_HEIGHT: height_ff <= csr_data[11:0];
               default:    mode_ff   <= mode_ff;
            endcase
            // any write restarts the frame
            p0_ff   <= '0;
            p1_ff   <= '0;
            p2_ff   <= '0;
            lag1_ff <= '0;
            lag2_ff <= '0;
         end else if (step) begin
            if (frame_end) begin
               p0_ff   <= '0;
               p1_ff   <= '0;
               p2_ff   <= '0;
               lag1_ff <= '0;
               lag2_ff <= '0;
            end else begin
               p0_ff <= p0_in;
               if (v1) begin
                  p1_ff <= p1_in;
                  if (v2) begin
                     p2_ff <= p2_in;
                  end else begin
                     lag2_ff <= lag2_ff + DLY_W'(1);
                  end
               end else begin
                  lag1_ff <= lag1_ff + DLY_W'(1);
               end
            end
         end
         if (adv) begin
            rsp_vld_ff <= emit;
         end
      end
      if (adv && emit) begin
         rsp_level_ff <= fin.level ? 8'hFF : 8'h00;
         rsp_row_ff   <= fin_last_row;
         rsp_frame_ff <= fin_last_row && (fin.ctr.row == ROW_W'(h_eff - 12'd1));
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tuser  = rsp_row_ff;
   assign rsp_tlast  = rsp_frame_ff;

endmodule
